// ===== rtl/c2d_pkg.sv =====
// shared types and constants for the fixed-point 2d convolution block
`timescale 1ns / 1ps

package c2d_pkg;

  localparam int IDX_W = 14;
  localparam int VAL_W = 16;
  localparam int RES_W = 32;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    OP_LOAD_FEATURE = 2'd0,
    OP_LOAD_WEIGHT  = 2'd1,
    OP_LOAD_BIAS    = 2'd2,
    OP_COMPUTE      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_INPUT_CHANNELS  = 3'd0,
    REG_INPUT_HEIGHT    = 3'd1,
    REG_INPUT_WIDTH     = 3'd2,
    REG_OUTPUT_CHANNELS = 3'd3,
    REG_OUTPUT_HEIGHT   = 3'd4,
    REG_OUTPUT_WIDTH    = 3'd5,
    REG_KERN_SIDE       = 3'd6,
    REG_PADDING         = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [4:0] input_channels;
    logic [5:0] input_height;
    logic [5:0] input_width;
    logic [4:0] output_channels;
    logic [5:0] output_height;
    logic [5:0] output_width;
    logic [2:0] kern_side;
    logic [2:0] padding;
  } cfg_t;

  localparam logic [4:0] RST_INPUT_CHANNELS  = 5'd1;
  localparam logic [5:0] RST_INPUT_HEIGHT    = 6'd32;
  localparam logic [5:0] RST_INPUT_WIDTH     = 6'd32;
  localparam logic [4:0] RST_OUTPUT_CHANNELS = 5'd1;
  localparam logic [5:0] RST_OUTPUT_HEIGHT   = 6'd32;
  localparam logic [5:0] RST_OUTPUT_WIDTH    = 6'd32;
  localparam logic [2:0] RST_KERN_SIDE       = 3'd3;
  localparam logic [2:0] RST_PADDING         = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_CH,
    ST_DIV_ROW,
    ST_PREP_A,
    ST_PREP_B,
    ST_MAC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic store_write;
    logic sub_plane;
    logic sub_row;
    logic prep_a;
    logic prep_b;
    logic mac_step;
    logic emit_err;
    logic emit_sum;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_compute;
    logic load_ok;
    logic rem_ge_plane;
    logic och_last;
    logic rem_ge_ow;
    logic tap_last;
    logic pipe_busy;
  } ctrl_status_t;

endpackage

// ===== rtl/c2d_regs.sv =====
// configuration register file behind the apb port
`timescale 1ns / 1ps

module c2d_regs
  import c2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_channels  <= RST_INPUT_CHANNELS;
      cfg.input_height    <= RST_INPUT_HEIGHT;
      cfg.input_width     <= RST_INPUT_WIDTH;
      cfg.output_channels <= RST_OUTPUT_CHANNELS;
      cfg.output_height   <= RST_OUTPUT_HEIGHT;
      cfg.output_width    <= RST_OUTPUT_WIDTH;
      cfg.kern_side       <= RST_KERN_SIDE;
      cfg.padding         <= RST_PADDING;
    end else if (wr_en) begin
      case (sel)
        REG_INPUT_CHANNELS:  cfg.input_channels  <= pwdata[4:0];
        REG_INPUT_HEIGHT:    cfg.input_height    <= pwdata[5:0];
        REG_INPUT_WIDTH:     cfg.input_width     <= pwdata[5:0];
        REG_OUTPUT_CHANNELS: cfg.output_channels <= pwdata[4:0];
        REG_OUTPUT_HEIGHT:   cfg.output_height   <= pwdata[5:0];
        REG_OUTPUT_WIDTH:    cfg.output_width    <= pwdata[5:0];
        REG_KERN_SIDE:       cfg.kern_side       <= pwdata[2:0];
        REG_PADDING:         cfg.padding         <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_INPUT_CHANNELS:  prdata = PDATA_W'(cfg.input_channels);
      REG_INPUT_HEIGHT:    prdata = PDATA_W'(cfg.input_height);
      REG_INPUT_WIDTH:     prdata = PDATA_W'(cfg.input_width);
      REG_OUTPUT_CHANNELS: prdata = PDATA_W'(cfg.output_channels);
      REG_OUTPUT_HEIGHT:   prdata = PDATA_W'(cfg.output_height);
      REG_OUTPUT_WIDTH:    prdata = PDATA_W'(cfg.output_width);
      REG_KERN_SIDE:       prdata = PDATA_W'(cfg.kern_side);
      REG_PADDING:         prdata = PDATA_W'(cfg.padding);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== rtl/c2d_ctrl.sv =====
// controller state machine sequencing loads, index decode and the mac loop
`timescale 1ns / 1ps

module c2d_ctrl
  import c2d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ctrl_status_t status,
  output logic         busy,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_compute) begin
          cmd.setup  = 1'b1;
          state_next = ST_DIV_CH;
        end else if (status.load_ok) begin
          cmd.store_write = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cmd.emit_err = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_DIV_CH: begin
        if (status.rem_ge_plane && status.och_last) begin
          cmd.emit_err = 1'b1;
          state_next   = ST_IDLE;
        end else if (status.rem_ge_plane) begin
          cmd.sub_plane = 1'b1;
        end else begin
          state_next = ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        if (status.rem_ge_ow) begin
          cmd.sub_row = 1'b1;
        end else begin
          state_next = ST_PREP_A;
        end
      end
      ST_PREP_A: begin
        cmd.prep_a = 1'b1;
        state_next = ST_PREP_B;
      end
      ST_PREP_B: begin
        cmd.prep_b = 1'b1;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        if (status.tap_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.emit_sum = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/c2d_datapath.sv =====
// datapath: stores, index decode, address generation, mac pipeline, result registers
`timescale 1ns / 1ps

module c2d_datapath
  import c2d_pkg::*;
#(
  parameter int MAX_CHANNELS     = 16,
  parameter int MAX_SIDE         = 32,
  parameter int MAX_KERNEL       = 5,
  parameter int MAX_OUT_CHANNELS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  ctrl_cmd_t               cmd,
  output ctrl_status_t            status,
  input  logic [1:0]              operation,
  input  logic [IDX_W-1:0]        index,
  input  logic signed [VAL_W-1:0] value,
  output logic                    result_valid,
  output logic [IDX_W-1:0]        position,
  output logic signed [RES_W-1:0] result_value,
  output logic                    index_error
);

  localparam int FEAT_DEPTH = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
  localparam int WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int FA_W  = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
  localparam int WA_W  = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int BA_W  = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int IC_W  = $clog2(MAX_CHANNELS + 1);
  localparam int OC_W  = $clog2(MAX_OUT_CHANNELS + 1);
  localparam int SD_W  = $clog2(MAX_SIDE + 1);
  localparam int K_W   = $clog2(MAX_KERNEL + 1);
  localparam int PL_W  = 2 * SD_W;
  localparam int KK_W  = 2 * K_W;
  localparam int CK_W  = IC_W + KK_W;
  localparam int WM_W  = OC_W + CK_W;
  localparam int CMP_W = (PL_W > IDX_W) ? PL_W : IDX_W;
  localparam int XW    = ((SD_W > K_W) ? SD_W : K_W) + 2;
  localparam int FS_W  = FA_W + 1;
  localparam int ACC_W = RES_W + $clog2(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1) + 1;

  logic signed [VAL_W-1:0] feat_mem [FEAT_DEPTH];
  logic signed [VAL_W-1:0] wgt_mem  [WGT_DEPTH];
  logic signed [VAL_W-1:0] bias_mem [MAX_OUT_CHANNELS];

  op_t                     op_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [VAL_W-1:0] val_q;

  logic [IC_W-1:0] ic_c;
  logic [OC_W-1:0] oc_c;
  logic [SD_W-1:0] ih_c, iw_c, oh_c, ow_c;
  logic [K_W-1:0]  k_c;

  logic [PL_W-1:0]  plane;
  logic [PL_W-1:0]  iplane;
  logic [KK_W-1:0]  kk;
  logic [CK_W-1:0]  ickk;
  logic [IDX_W-1:0] rem;
  logic [OC_W-1:0]  och;
  logic [SD_W-1:0]  row;
  logic [SD_W-1:0]  col;

  logic [IC_W-1:0] ch;
  logic [K_W-1:0]  kr, kc;
  logic [FA_W-1:0] fch;
  logic [WA_W-1:0] waddr;

  logic signed [XW-1:0] x, y;
  logic                 inb;
  logic [FA_W-1:0]      fa_n;

  logic [FA_W-1:0]         fa_q;
  logic [WA_W-1:0]         wa_q;
  logic                    v1, v2, v3;
  logic signed [VAL_W-1:0] fdat, wdat, bias_q;
  logic signed [RES_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic                    acc_ovf;
  logic signed [RES_W-1:0] acc_sat;

  // size registers limited to the legal range
  always_comb begin
    ic_c = (cfg.input_channels == '0) ? IC_W'(1) :
           (32'(cfg.input_channels) > MAX_CHANNELS) ? IC_W'(MAX_CHANNELS) :
           IC_W'(cfg.input_channels);
    oc_c = (cfg.output_channels == '0) ? OC_W'(1) :
           (32'(cfg.output_channels) > MAX_OUT_CHANNELS) ? OC_W'(MAX_OUT_CHANNELS) :
           OC_W'(cfg.output_channels);
    ih_c = (cfg.input_height == '0) ? SD_W'(1) :
           (32'(cfg.input_height) > MAX_SIDE) ? SD_W'(MAX_SIDE) : SD_W'(cfg.input_height);
    iw_c = (cfg.input_width == '0) ? SD_W'(1) :
           (32'(cfg.input_width) > MAX_SIDE) ? SD_W'(MAX_SIDE) : SD_W'(cfg.input_width);
    oh_c = (cfg.output_height == '0) ? SD_W'(1) :
           (32'(cfg.output_height) > MAX_SIDE) ? SD_W'(MAX_SIDE) : SD_W'(cfg.output_height);
    ow_c = (cfg.output_width == '0) ? SD_W'(1) :
           (32'(cfg.output_width) > MAX_SIDE) ? SD_W'(MAX_SIDE) : SD_W'(cfg.output_width);
    k_c  = (cfg.kern_side == '0) ? K_W'(1) :
           (32'(cfg.kern_side) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : K_W'(cfg.kern_side);
  end

  // status toward the controller
  always_comb begin
    status.is_compute   = (op_q == OP_COMPUTE);
    case (op_q)
      OP_LOAD_FEATURE: status.load_ok = (32'(idx_q) < FEAT_DEPTH);
      OP_LOAD_WEIGHT:  status.load_ok = (32'(idx_q) < WGT_DEPTH);
      OP_LOAD_BIAS:    status.load_ok = (32'(idx_q) < MAX_OUT_CHANNELS);
      default:         status.load_ok = 1'b0;
    endcase
    status.rem_ge_plane = (CMP_W'(rem) >= CMP_W'(plane));
    status.och_last     = (och == oc_c - OC_W'(1));
    status.rem_ge_ow    = (CMP_W'(rem) >= CMP_W'(ow_c));
    status.tap_last     = (ch == ic_c - IC_W'(1)) && (kr == k_c - K_W'(1)) &&
                          (kc == k_c - K_W'(1));
    status.pipe_busy    = v1 | v2 | v3;
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(operation);
      idx_q <= index;
      val_q <= value;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (cmd.store_write && op_q == OP_LOAD_FEATURE) begin
      feat_mem[FA_W'(idx_q)] <= val_q;
    end
    fdat <= feat_mem[fa_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.store_write && op_q == OP_LOAD_WEIGHT) begin
      wgt_mem[WA_W'(idx_q)] <= val_q;
    end
    wdat <= wgt_mem[wa_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.store_write && op_q == OP_LOAD_BIAS) begin
      bias_mem[BA_W'(idx_q)] <= val_q;
    end
    bias_q <= bias_mem[och[BA_W-1:0]];
  end

  // position decode by repeated subtraction
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      plane  <= PL_W'(oh_c) * PL_W'(ow_c);
      iplane <= PL_W'(ih_c) * PL_W'(iw_c);
      kk     <= KK_W'(k_c) * KK_W'(k_c);
      rem    <= idx_q;
      och    <= '0;
      row    <= '0;
    end else if (cmd.sub_plane) begin
      rem <= IDX_W'(CMP_W'(rem) - CMP_W'(plane));
      och <= och + OC_W'(1);
    end else if (cmd.sub_row) begin
      rem <= IDX_W'(CMP_W'(rem) - CMP_W'(ow_c));
      row <= row + SD_W'(1);
    end
    if (cmd.prep_a) begin
      col  <= SD_W'(rem);
      ickk <= CK_W'(ic_c) * CK_W'(kk);
    end
  end

  // tap coordinates and feature address
  always_comb begin
    x    = XW'(row) - XW'(cfg.padding) + XW'(kr);
    y    = XW'(col) - XW'(cfg.padding) + XW'(kc);
    inb  = !x[XW-1] && (x < XW'(ih_c)) && !y[XW-1] && (y < XW'(iw_c));
    fa_n = FA_W'(FS_W'(fch) + FS_W'(x[SD_W-1:0]) * FS_W'(iw_c) + FS_W'(y[SD_W-1:0]));
  end

  // tap counters
  always_ff @(posedge clk) begin
    if (cmd.prep_b) begin
      waddr <= WA_W'(WM_W'(och) * WM_W'(ickk));
      ch    <= '0;
      kr    <= '0;
      kc    <= '0;
      fch   <= '0;
    end else if (cmd.mac_step) begin
      waddr <= waddr + WA_W'(1);
      if (kc == k_c - K_W'(1)) begin
        kc <= '0;
        if (kr == k_c - K_W'(1)) begin
          kr  <= '0;
          ch  <= ch + IC_W'(1);
          fch <= fch + FA_W'(iplane);
        end else begin
          kr <= kr + K_W'(1);
        end
      end else begin
        kc <= kc + K_W'(1);
      end
    end
  end

  // mac pipeline: address, store read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.mac_step & inb;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    fa_q <= fa_n;
    wa_q <= waddr;
    prod <= fdat * wdat;
    if (cmd.prep_b) begin
      acc <= {{(ACC_W-VAL_W-8){bias_q[VAL_W-1]}}, bias_q, 8'b0};
    end else if (v3) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // saturation to 32 bits
  always_comb begin
    acc_ovf = !((&acc[ACC_W-1:RES_W-1]) || !(|acc[ACC_W-1:RES_W-1]));
    if (acc_ovf) begin
      acc_sat = acc[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      acc_sat = acc[RES_W-1:0];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_err | cmd.emit_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      position     <= idx_q;
      result_value <= '0;
      index_error  <= 1'b1;
    end else if (cmd.emit_sum) begin
      position     <= idx_q;
      result_value <= acc_sat;
      index_error  <= 1'b0;
    end
  end

endmodule

// ===== rtl/conv2d_fixed_point.sv =====
// top level of the fixed-point multi-channel 2d convolution block
//
// usage: sizes are set over the apb port while the block is idle. a transaction
// is taken at a clock edge with start high and busy low. operations 0, 1 and 2
// write the feature, weight or bias store at index; operation 3 computes the
// output at flat position index (channel, row, column) as bias plus the sum of
// in-bounds taps over all input channels, Q16.16 saturated to 32 bits.
// a result shows for one cycle with result_valid high; the receiver cannot stall.
// a good load gives no result and busy drops again after the decode state; a bad
// load address gives an index_error result through the decode state and the
// result registers. in a compute the position is split by repeated subtraction
// (one step per output channel and per row), then one multiply-accumulate runs
// per kernel tap through a single multiplier, reading one feature and one weight
// store word per cycle, then the pipeline drains. one transaction is worked at
// a time. reset returns the sizes to their defaults and the controller to idle;
// the stores hold no defined contents until written.

`timescale 1ns / 1ps

module conv2d_fixed_point
  import c2d_pkg::*;
#(
  parameter int MAX_CHANNELS     = 16,
  parameter int MAX_SIDE         = 32,
  parameter int MAX_KERNEL       = 5,
  parameter int MAX_OUT_CHANNELS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation,
  input  logic [IDX_W-1:0]        index,
  input  logic signed [VAL_W-1:0] value,
  output logic                    result_valid,
  output logic [IDX_W-1:0]        position,
  output logic signed [RES_W-1:0] result_value,
  output logic                    index_error
);

  cfg_t         cfg;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  c2d_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  c2d_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  c2d_datapath #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .MAX_SIDE         (MAX_SIDE),
    .MAX_KERNEL       (MAX_KERNEL),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .index        (index),
    .value        (value),
    .result_valid (result_valid),
    .position     (position),
    .result_value (result_value),
    .index_error  (index_error)
  );

endmodule

// ===== rtl/c2d_checker.sv =====
// port-level checker for the convolution block and its bind
`timescale 1ns / 1ps

module c2d_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);

  // an accepted transaction always occupies the block the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  // a result shows only once work is done
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while busy");

  // results never come back to back
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on consecutive cycles");

  // a result follows a busy cycle
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a transaction in flight");

endmodule

bind conv2d_fixed_point c2d_checker u_c2d_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid)
);
